// ----- rtl/sdlp_pkg.sv -----
package sdlp_pkg;

   // Width of the radius fields carried on both channels.
   localparam int FIELD_BITS = 16;

endpackage

// ----- rtl/sdlp_req_if.sv -----
// Pixel words into the pass: one radius and the end-of-line mark.
interface sdlp_req_if
   import sdlp_pkg::*;
();

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] radius_in;
   logic                  last_in_line;

   modport source (output valid, output radius_in, output last_in_line, input ready);
   modport sink   (input valid, input radius_in, input last_in_line, output ready);

endinterface

// ----- rtl/sdlp_rsp_if.sv -----
// Result words out of the pass: the covering radius and the line flags.
interface sdlp_rsp_if
   import sdlp_pkg::*;
();

   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] radius_out;
   logic                  last_out;
   logic                  line_too_long;

   modport source (output valid, output radius_out, output last_out,
                   output line_too_long, input ready);
   modport sink   (input valid, input radius_out, input last_out,
                   input line_too_long, output ready);

endinterface

// ----- rtl/sdlp_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module sdlp_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read share the clock edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/square_dilation_line_pass_core.sv -----
// One directional pass of a square dilation along an image line. Pixel radii
// arrive one word at a time; each word returns one word holding the radius of
// the square that covers that pixel, a copy of the end-of-line mark and a flag
// that is set when the line reached LINE_MAX pixels without an end mark and
// was ended there. Each word passes the idle, expire and trim states, staying
// in trim while it drops candidates from the deque's back or the result
// register is occupied; the deque RAM has a single read port, read once for
// the front entry and once per dropped back entry. Drops are bounded by
// pushes; no new word is taken until the last is finished. A reverse pass is
// made by feeding the line in reverse order. All line state clears after the
// last pixel of a line, and the deque RAM needs no clearing pass after reset.
module square_dilation_line_pass_core
   import sdlp_pkg::*;
#(
   parameter int LINE_MAX    = 1024,
   parameter int RADIUS_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   sdlp_req_if.sink  req_chan,
   sdlp_rsp_if.source rsp_chan
);

   localparam int RW = (RADIUS_BITS < FIELD_BITS) ? RADIUS_BITS : FIELD_BITS;
   localparam int PW = $clog2(LINE_MAX);
   localparam int QW = $clog2(LINE_MAX + 1);
   localparam int SW = ((PW > RW) ? PW : RW) + 1;
   localparam int EW = RW + PW;
   localparam logic [PW-1:0] LAST_POS  = PW'(LINE_MAX - 1);
   localparam logic [QW-1:0] QUEUE_CAP = QW'(LINE_MAX);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXPIRE,
      S_TRIM
   } state_type;

   state_type             state_ff;
   logic [RW-1:0]         v_ff;
   logic                  last_ff;
   logic [PW-1:0]         pos_ff;
   logic [RW-1:0]         act_r_ff;
   logic [PW-1:0]         act_s_ff;
   logic [QW-1:0]         head_ff;
   logic [QW-1:0]         tail_ff;
   logic [RW-1:0]         back_r_ff;
   logic [PW-1:0]         back_p_ff;
   logic                  back_sel_ff;
   logic                  rsp_valid_ff;
   logic [FIELD_BITS-1:0] rsp_radius_ff;
   logic                  rsp_last_ff;
   logic                  rsp_long_ff;

   logic [PW-1:0] rd_addr;
   logic [EW-1:0] rd_data;
   logic [RW-1:0] rd_r;
   logic [PW-1:0] rd_p;
   logic          wr_en;
   logic [QW-1:0] tail_minus2;
   logic [RW-1:0] back_r;
   logic [PW-1:0] back_p;
   logic [SW-1:0] act_reach;
   logic [SW-1:0] new_reach;
   logic [SW-1:0] back_reach;
   logic          nonempty;
   logic          expire;
   logic          pop;
   logic          push_ok;
   logic          do_push;
   logic          replace;
   logic          out_free;
   logic          finish;
   logic          too_long;

   // Deque entries: radius in the upper bits, position in the lower bits.
   sdlp_ram #(
      .WIDTH (EW),
      .DEPTH (LINE_MAX)
   ) u_deque_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff[PW-1:0]),
      .wr_data ({v_ff, pos_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_r = rd_data[EW-1:PW];
   assign rd_p = rd_data[PW-1:0];

   // The front is read while idle; during trimming the entry below the back.
   assign tail_minus2 = tail_ff - QW'(2);
   assign rd_addr     = (state_ff == S_IDLE) ? head_ff[PW-1:0] : tail_minus2[PW-1:0];

   // The back entry is cached, or arrives from the RAM just after a drop.
   assign back_r = back_sel_ff ? rd_r : back_r_ff;
   assign back_p = back_sel_ff ? rd_p : back_p_ff;

   // Reach comparisons, formed one bit wider so that they never wrap.
   assign act_reach  = SW'(act_s_ff) + SW'(act_r_ff);
   assign new_reach  = SW'(v_ff) + SW'(pos_ff);
   assign back_reach = SW'(back_r) + SW'(back_p);

   assign nonempty = (head_ff != tail_ff);
   assign expire   = (act_reach == SW'(pos_ff));
   assign pop      = nonempty && (v_ff >= back_r);
   assign push_ok  = nonempty ? (back_reach < new_reach) : (act_reach < new_reach);
   assign do_push  = push_ok && (tail_ff < QUEUE_CAP);
   assign replace  = (v_ff >= act_r_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign finish   = (state_ff == S_TRIM) && !pop && out_free;
   assign too_long = !last_ff && (pos_ff == LAST_POS);

   assign wr_en = finish && do_push;

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.radius_out    = rsp_radius_ff;
   assign rsp_chan.last_out      = rsp_last_ff;
   assign rsp_chan.line_too_long = rsp_long_ff;

   // Sequencer: take a word, expire the active square, trim the back, finish.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         act_r_ff     <= '0;
         act_s_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         back_sel_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The result register fills on a finished word and empties when taken.
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  v_ff     <= req_chan.radius_in[RW-1:0];
                  last_ff  <= req_chan.last_in_line;
                  state_ff <= S_EXPIRE;
               end
            end

            S_EXPIRE: begin
               // The front entry read while idle replaces an expired square.
               if (expire) begin
                  if (nonempty) begin
                     act_r_ff <= rd_r;
                     act_s_ff <= rd_p;
                     head_ff  <= head_ff + QW'(1);
                  end else begin
                     act_r_ff <= v_ff;
                     act_s_ff <= pos_ff;
                  end
               end
               back_sel_ff <= 1'b0;
               state_ff    <= S_TRIM;
            end

            S_TRIM: begin
               if (pop) begin
                  // Drop the back; the next entry down arrives next cycle.
                  back_r_ff   <= back_r;
                  back_p_ff   <= back_p;
                  tail_ff     <= tail_ff - QW'(1);
                  back_sel_ff <= 1'b1;
               end else if (out_free) begin
                  // The cached back becomes this pixel when it is pushed.
                  back_r_ff     <= do_push ? v_ff : back_r;
                  back_p_ff     <= do_push ? pos_ff : back_p;
                  back_sel_ff   <= 1'b0;
                  rsp_radius_ff <= FIELD_BITS'(replace ? v_ff : act_r_ff);
                  rsp_last_ff   <= last_ff;
                  rsp_long_ff   <= too_long;
                  if (last_ff || too_long) begin
                     act_r_ff <= '0;
                     act_s_ff <= '0;
                     pos_ff   <= '0;
                     head_ff  <= '0;
                     tail_ff  <= '0;
                  end else begin
                     pos_ff <= pos_ff + PW'(1);
                     // A square at least as large takes over and empties the deque.
                     if (replace) begin
                        act_r_ff <= v_ff;
                        act_s_ff <= pos_ff;
                        tail_ff  <= head_ff;
                     end else if (do_push) begin
                        tail_ff <= tail_ff + QW'(1);
                     end
                  end
                  state_ff <= S_IDLE;
               end else begin
                  // Output still occupied: hold with the back entry cached.
                  back_r_ff   <= back_r;
                  back_p_ff   <= back_p;
                  back_sel_ff <= 1'b0;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
